### rtl/core/ps2me_pkg.sv
`default_nettype none

package ps2me_pkg;

    // Event codes carried in event_kind.
    typedef enum logic [2:0] {
        EV_LDOWN = 3'd0,
        EV_LUP   = 3'd1,
        EV_MDOWN = 3'd2,
        EV_MUP   = 3'd3,
        EV_RDOWN = 3'd4,
        EV_RUP   = 3'd5,
        EV_MOVE  = 3'd6
    } event_kind_t;

    // Position of the next byte within a three-byte packet.
    localparam logic [1:0] POS_STATUS = 2'd0;
    localparam logic [1:0] POS_XBYTE  = 2'd1;
    localparam logic [1:0] POS_YBYTE  = 2'd2;

    // Status byte bit positions.
    localparam int BIT_LEFT   = 0;
    localparam int BIT_RIGHT  = 1;
    localparam int BIT_MIDDLE = 2;
    localparam int BIT_XSIGN  = 4;
    localparam int BIT_YSIGN  = 5;

    // Widths of the stream payloads.
    localparam int IN_DATA_W  = 32;
    localparam int OUT_DATA_W = 48;

    // One decoded event as passed from the decoder to the result register.
    typedef struct packed {
        logic               valid;
        event_kind_t        kind;
        logic [9:0]         pos_x;
        logic [9:0]         pos_y;
        logic signed [8:0]  delta_x;
        logic signed [9:0]  delta_y;
    } event_t;

endpackage

`default_nettype wire

### rtl/core/ps2me_decoder.sv
`default_nettype none

module ps2me_decoder (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             step,
    input  wire logic [7:0]       data_byte,
    input  wire logic [9:0]       cursor_x,
    input  wire logic [9:0]       cursor_y,
    output ps2me_pkg::event_t     result
);
    import ps2me_pkg::*;

    logic [1:0] pos_reg, pos_next;
    logic [7:0] status_reg, status_next;
    logic [7:0] xbyte_reg, xbyte_next;
    logic       left_reg, left_next;
    logic       middle_reg, middle_next;
    logic       right_reg, right_next;

    logic signed [8:0] dx;
    logic signed [8:0] dy_raw;
    logic signed [9:0] dy;

    // Sign-extended deltas; the Y delta is negated so that up is negative.
    assign dx     = {status_reg[BIT_XSIGN], xbyte_reg};
    assign dy_raw = {status_reg[BIT_YSIGN], data_byte};
    assign dy     = 10'sd0 - {dy_raw[8], dy_raw};

    // Packet framing, button edge detection and move decoding.
    always_comb
    begin
        pos_next    = pos_reg;
        status_next = status_reg;
        xbyte_next  = xbyte_reg;
        left_next   = left_reg;
        middle_next = middle_reg;
        right_next  = right_reg;
        result      = '0;
        if (step)
        begin
            unique case (pos_reg)
                POS_STATUS:
                begin
                    status_next = data_byte;
                    pos_next    = POS_XBYTE;
                end
                POS_XBYTE:
                begin
                    xbyte_next = data_byte;
                    pos_next   = POS_YBYTE;
                end
                default:
                begin
                    pos_next = POS_STATUS;
                    priority if (status_reg[BIT_LEFT] != left_reg)
                    begin
                        left_next    = status_reg[BIT_LEFT];
                        result.valid = 1'b1;
                        if (status_reg[BIT_LEFT])
                        begin
                            result.kind  = EV_LDOWN;
                            result.pos_x = cursor_x;
                            result.pos_y = cursor_y;
                        end
                        else
                        begin
                            result.kind = EV_LUP;
                        end
                    end
                    else if (status_reg[BIT_MIDDLE] != middle_reg)
                    begin
                        middle_next  = status_reg[BIT_MIDDLE];
                        result.valid = 1'b1;
                        result.kind  = status_reg[BIT_MIDDLE] ? EV_MDOWN : EV_MUP;
                    end
                    else if (status_reg[BIT_RIGHT] != right_reg)
                    begin
                        right_next   = status_reg[BIT_RIGHT];
                        result.valid = 1'b1;
                        if (status_reg[BIT_RIGHT])
                        begin
                            result.kind  = EV_RDOWN;
                            result.pos_x = cursor_x;
                            result.pos_y = cursor_y;
                        end
                        else
                        begin
                            result.kind = EV_RUP;
                        end
                    end
                    else
                    begin
                        result.valid   = (dx != 9'sd0) || (dy != 10'sd0);
                        result.kind    = EV_MOVE;
                        result.delta_x = dx;
                        result.delta_y = dy;
                    end
                end
            endcase
        end
    end

    // Packet and button state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= POS_STATUS;
            status_reg <= '0;
            xbyte_reg  <= '0;
            left_reg   <= 1'b0;
            middle_reg <= 1'b0;
            right_reg  <= 1'b0;
        end
        else
        begin
            pos_reg    <= pos_next;
            status_reg <= status_next;
            xbyte_reg  <= xbyte_next;
            left_reg   <= left_next;
            middle_reg <= middle_next;
            right_reg  <= right_next;
        end
    end

endmodule

`default_nettype wire

### rtl/core/ps2_mouse_packet_events_core.sv
// An item accepted on s_axis passes the input register, then the result register,
// before it can be taken from m_axis; a stalled output side holds it back.
// Throughput: one item per cycle unless m_axis stalls; decode is a single logic pass.
// Items that complete no event (status byte, X byte, idle packet) give no result.
// Reset (rst_n low, asynchronous) clears both registers' valid flags, the packet
// position, the held bytes and the button flags.
`default_nettype none

module ps2_mouse_packet_events_core (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 s_axis_tvalid,
    output      logic                                 s_axis_tready,
    // [7:0] data_byte, [17:8] cursor_x, [27:18] cursor_y, [31:28] zero
    input  wire logic [ps2me_pkg::IN_DATA_W-1:0]      s_axis_tdata,
    output      logic                                 m_axis_tvalid,
    input  wire logic                                 m_axis_tready,
    // [2:0] event_kind, [12:3] pos_x, [22:13] pos_y, [31:23] delta_x,
    // [41:32] delta_y, [47:42] zero
    output      logic [ps2me_pkg::OUT_DATA_W-1:0]     m_axis_tdata
);
    import ps2me_pkg::*;

    logic       in_valid_reg, in_valid_next;
    logic [7:0] in_byte_reg;
    logic [9:0] in_cx_reg;
    logic [9:0] in_cy_reg;
    logic       out_valid_reg, out_valid_next;
    event_t     out_reg;
    event_t     result;
    logic       s_accept;
    logic       advance;

    // Handshakes: the input item moves on when the result slot is free or draining.
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign s_accept      = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (s_accept)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = result.valid;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            in_byte_reg <= s_axis_tdata[7:0];
            in_cx_reg   <= s_axis_tdata[17:8];
            in_cy_reg   <= s_axis_tdata[27:18];
        end
    end

    // Packet decoder.
    ps2me_decoder u_decoder (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (advance),
        .data_byte (in_byte_reg),
        .cursor_x  (in_cx_reg),
        .cursor_y  (in_cy_reg),
        .result    (result)
    );

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && result.valid)
        begin
            out_reg <= result;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {6'd0, out_reg.delta_y, out_reg.delta_x, out_reg.pos_y,
                            out_reg.pos_x, out_reg.kind};

    // A decoded event always reaches the result register in the next cycle.
    a_event_lands: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && result.valid) |=> m_axis_tvalid)
        else $error("decoded event not presented");

    // A held input item blocks further input.
    a_input_blocked: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !advance) |-> !s_axis_tready)
        else $error("input accepted over a held item");

    // Button events carry no movement.
    a_button_no_delta: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && out_reg.kind != EV_MOVE) |->
        (out_reg.delta_x == 9'sd0 && out_reg.delta_y == 10'sd0))
        else $error("button event with movement");

    // Move events carry no position.
    a_move_no_pos: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && out_reg.kind == EV_MOVE) |->
        (out_reg.pos_x == 10'd0 && out_reg.pos_y == 10'd0))
        else $error("move event with position");

endmodule

`default_nettype wire

### verif/tb_ps2_mouse_packet_events_core.sv
`timescale 1ns / 100ps

module tb_ps2_mouse_packet_events_core;
    import ps2me_pkg::*;

    localparam int CLK_HALF     = 10;
    localparam int STALL_LIMIT  = 5000;
    localparam int HOLD_CYCLES  = 300;
    localparam int TARGET_ITEMS = 1450;
    localparam int DRAIN_CYCLES = 8;

    // One expected or observed event, split into its fields.
    typedef struct packed {
        event_kind_t       kind;
        logic [9:0]        px;
        logic [9:0]        py;
        logic signed [8:0] dx;
        logic signed [9:0] dy;
    } mouse_event_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    // [7:0] data_byte, [17:8] cursor_x, [27:18] cursor_y, [31:28] zero
    logic [31:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    // [2:0] event_kind, [12:3] pos_x, [22:13] pos_y, [31:23] delta_x,
    // [41:32] delta_y, [47:42] zero
    logic [47:0] m_axis_tdata;

    // Pending input items and events still to arrive.
    logic [27:0]  byte_q[$];
    mouse_event_t event_q[$];

    int total_items = 0;
    int in_count = 0;
    int out_count = 0;
    int mismatches = 0;
    int idle_cycles = 0;
    int kind_count[0:7];
    int hold_left = 0;
    bit hold_done = 1'b0;

    // Shadow of the decoder state.
    logic [1:0] pkt_pos = POS_STATUS;
    logic [7:0] stat_byte = '0;
    logic [7:0] x_byte = '0;
    logic       btn_l = 1'b0;
    logic       btn_m = 1'b0;
    logic       btn_r = 1'b0;

    ps2_mouse_packet_events_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial
    begin
        forever #CLK_HALF clk = ~clk;
    end

    // Idle percentages by phase: sender then receiver, swapped, then none.
    function automatic int send_idle_pct();
        if (in_count < total_items / 3)
            return 11;
        else if (in_count < (2 * total_items) / 3)
            return 77;
        return 0;
    endfunction

    function automatic int recv_idle_pct();
        if (in_count < total_items / 3)
            return 77;
        else if (in_count < (2 * total_items) / 3)
            return 11;
        return 0;
    endfunction

    // Advance the shadow decoder by one byte and queue any event it yields.
    task automatic decode_byte(input logic [27:0] item);
        logic [7:0]        data;
        logic [9:0]        cx;
        logic [9:0]        cy;
        logic              hit;
        mouse_event_t      ev;
        logic signed [9:0] y_ext;
        begin
            data = item[7:0];
            cx   = item[17:8];
            cy   = item[27:18];
            hit  = 1'b0;
            ev   = '0;
            if (pkt_pos == POS_STATUS)
            begin
                stat_byte = data;
                pkt_pos   = POS_XBYTE;
            end
            else if (pkt_pos == POS_XBYTE)
            begin
                x_byte  = data;
                pkt_pos = POS_YBYTE;
            end
            else
            begin
                pkt_pos = POS_STATUS;
                // Buttons are examined left, middle, right; the first edge wins.
                if (stat_byte[BIT_LEFT] != btn_l)
                begin
                    btn_l   = stat_byte[BIT_LEFT];
                    ev.kind = btn_l ? EV_LDOWN : EV_LUP;
                    hit     = 1'b1;
                end
                else if (stat_byte[BIT_MIDDLE] != btn_m)
                begin
                    btn_m   = stat_byte[BIT_MIDDLE];
                    ev.kind = btn_m ? EV_MDOWN : EV_MUP;
                    hit     = 1'b1;
                end
                else if (stat_byte[BIT_RIGHT] != btn_r)
                begin
                    btn_r   = stat_byte[BIT_RIGHT];
                    ev.kind = btn_r ? EV_RDOWN : EV_RUP;
                    hit     = 1'b1;
                end
                if (hit)
                begin
                    if (ev.kind == EV_LDOWN || ev.kind == EV_RDOWN)
                    begin
                        ev.px = cx;
                        ev.py = cy;
                    end
                    event_q.push_back(ev);
                end
                else
                begin
                    // No edge: movement with a nine-bit X and a ten-bit Y delta, Y negated.
                    ev.kind = EV_MOVE;
                    ev.dx   = {stat_byte[BIT_XSIGN], x_byte};
                    y_ext   = {{2{stat_byte[BIT_YSIGN]}}, data};
                    ev.dy   = -y_ext;
                    if (ev.dx != 0 || ev.dy != 0)
                        event_q.push_back(ev);
                end
            end
        end
    endtask

    // Input driver: keeps an item on the bus until it is taken.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                decode_byte(s_axis_tdata[27:0]);
                in_count++;
            end
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (byte_q.size() != 0 && $urandom_range(99) >= send_idle_pct())
                begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= {4'b0000, byte_q.pop_front()};
                end
                else
                begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Long hold-off of the receiver, once, during the phase with no idling.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end
        else if (!hold_done && total_items != 0
                 && in_count >= (2 * total_items) / 3 + 100)
        begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
        end
    end

    // Receiver ready.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
            m_axis_tready <= (hold_left == 0) && ($urandom_range(99) >= recv_idle_pct());
    end

    // Result monitor: each event is compared with the oldest expectation.
    always @(posedge clk)
    begin
        mouse_event_t got;
        mouse_event_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.kind = event_kind_t'(m_axis_tdata[2:0]);
            got.px   = m_axis_tdata[12:3];
            got.py   = m_axis_tdata[22:13];
            got.dx   = m_axis_tdata[31:23];
            got.dy   = m_axis_tdata[41:32];
            out_count++;
            kind_count[m_axis_tdata[2:0]]++;
            if (event_q.size() == 0)
            begin
                mismatches++;
                $display("%0t: unexpected event, expected none, actual kind %0d",
                         $time, got.kind);
            end
            else
            begin
                want = event_q.pop_front();
                if (got.kind != want.kind)
                begin
                    mismatches++;
                    $display("%0t: event_kind expected %0d actual %0d",
                             $time, want.kind, got.kind);
                end
                if (got.px != want.px)
                begin
                    mismatches++;
                    $display("%0t: pos_x expected %0d actual %0d", $time, want.px, got.px);
                end
                if (got.py != want.py)
                begin
                    mismatches++;
                    $display("%0t: pos_y expected %0d actual %0d", $time, want.py, got.py);
                end
                if (got.dx != want.dx)
                begin
                    mismatches++;
                    $display("%0t: delta_x expected %0d actual %0d", $time, want.dx, got.dx);
                end
                if (got.dy != want.dy)
                begin
                    mismatches++;
                    $display("%0t: delta_y expected %0d actual %0d", $time, want.dy, got.dy);
                end
            end
        end
    end

    // Watchdog on cycles in which no item moves on either side.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("%0t: no progress for %0d cycles", $time, idle_cycles);
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    task automatic push_packet(input logic [7:0] status, input logic [7:0] xb,
                               input logic [7:0] yb, input logic [9:0] cx,
                               input logic [9:0] cy);
        begin
            byte_q.push_back({10'($urandom_range(599)), 10'($urandom_range(799)), status});
            byte_q.push_back({10'($urandom_range(599)), 10'($urandom_range(799)), xb});
            byte_q.push_back({cy, cx, yb});
        end
    endtask

    function automatic logic [7:0] pick_delta();
        case ($urandom_range(7))
            0: return 8'h00;
            1: return 8'hFF;
            2: return 8'h80;
            3: return 8'h01;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    function automatic logic [9:0] pick_cursor(input int top);
        if ($urandom_range(7) == 0)
            return 10'($urandom_range(1023));
        return 10'($urandom_range(top));
    endfunction

    // Stimulus, then the drain and the verdict.
    initial
    begin
        logic [7:0] status;
        logic [7:0] xb;
        logic [7:0] yb;
        logic [2:0] prev_btns;
        int         extra;
        foreach (kind_count[k])
            kind_count[k] = 0;

        // Directed: idle packet, every press, left and middle release, extremes of the deltas.
        push_packet(8'h00, 8'h00, 8'h00, 10'd5, 10'd5);         // no edge, no movement
        push_packet(8'h01, 8'h12, 8'h34, 10'd799, 10'd599);     // left down, movement dropped
        push_packet(8'h31, 8'hFF, 8'h80, 10'd0, 10'd0);         // held left, dx -1, dy 128
        push_packet(8'h05, 8'h00, 8'h00, 10'd100, 10'd200);     // middle down
        push_packet(8'h07, 8'h7F, 8'h7F, 10'd1023, 10'd1023);   // right down, cursor beyond range
        push_packet(8'h37, 8'h00, 8'h00, 10'd0, 10'd0);         // dx -256, dy 256
        push_packet(8'h0F, 8'h7F, 8'hFF, 10'd0, 10'd0);         // sync bit ignored, dx 127, dy -255
        push_packet(8'h00, 8'h00, 8'h00, 10'd300, 10'd300);     // left up
        push_packet(8'hC0, 8'h55, 8'hAA, 10'd300, 10'd300);     // middle up
        byte_q.push_back({10'd0, 10'd0, 8'h00});                // stray byte shifts the framing
        prev_btns = 3'b010;

        // Random packets, mostly well framed, with the odd stray byte.
        while (byte_q.size() < TARGET_ITEMS)
        begin
            status = 8'($urandom_range(255));
            if ($urandom_range(9) < 6)
                status[2:0] = prev_btns;
            prev_btns = status[2:0];
            xb = pick_delta();
            yb = pick_delta();
            if ($urandom_range(9) == 0)
            begin
                status[5:4] = 2'b00;
                xb = 8'h00;
                yb = 8'h00;
            end
            push_packet(status, xb, yb, pick_cursor(799), pick_cursor(599));
            if ($urandom_range(19) == 0)
            begin
                extra = $urandom_range(2, 1);
                repeat (extra)
                    byte_q.push_back({pick_cursor(599), pick_cursor(799),
                                      8'($urandom_range(255))});
            end
        end
        total_items = byte_q.size();

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Wait for every item to be taken and every event to arrive.
        while (byte_q.size() != 0 || s_axis_tvalid)
            @(posedge clk);
        while (event_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (event_q.size() != 0)
        begin
            mismatches++;
            $display("%0t: %0d expected events never arrived", $time, event_q.size());
        end
        $display("Run covered %0d bytes and %0d events across three idle patterns",
                 in_count, out_count);
        $display("Events by kind ldown..move: %0d %0d %0d %0d %0d %0d %0d",
                 kind_count[0], kind_count[1], kind_count[2], kind_count[3],
                 kind_count[4], kind_count[5], kind_count[6]);
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

### files.f
rtl/core/ps2me_pkg.sv
rtl/core/ps2me_decoder.sv
rtl/core/ps2_mouse_packet_events_core.sv
verif/tb_ps2_mouse_packet_events_core.sv
